// ===== rtl/quaternion_multiply_normalize_unit_assert.svh =====
`ifndef QUATERNION_MULTIPLY_NORMALIZE_UNIT_ASSERT_SVH
`define QUATERNION_MULTIPLY_NORMALIZE_UNIT_ASSERT_SVH
// Assertion helpers
`define QMN_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error("qmn check failed");
`define QMN_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error("qmn check failed");
`endif

// ===== rtl/qmn_pkg.sv =====
`timescale 1ns / 1ps
package qmn_pkg;
  localparam int unsigned CompW = 16;
  localparam int unsigned ProdW = 34;
  localparam int unsigned MagW  = 33;
  localparam int unsigned ScW   = 31;
  localparam int unsigned SqW   = 64;
  localparam int unsigned RootW = 32;

  typedef logic signed [CompW-1:0] comp_t;

  typedef struct packed {
    comp_t lw, lx, ly, lz, rw, rx, ry, rz;
  } qin_t;

  typedef struct packed {
    comp_t w, x, y, z;
    logic  zero_length;
  } qout_t;
endpackage

// ===== rtl/qmn_if.sv =====
`timescale 1ns / 1ps
interface qmn_in_if import qmn_pkg::*; ();
  logic valid;
  logic ready;
  qin_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qmn_out_if import qmn_pkg::*; ();
  logic  valid;
  logic  ready;
  qout_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/quaternion_multiply_normalize_unit.sv =====
`timescale 1ns / 1ps
// Normalised Hamilton quaternion product. One item per cycle in and out while the
// pipe is not stalled. The pipeline holds the product stages, the square root
// (two bits a stage), the divider (FRAC_BITS + 2 stages, one quotient bit each)
// and 1 output register. Valid bits travel with the data; the whole pipe
// advances whenever the output register is empty or being read.
module quaternion_multiply_normalize_unit import qmn_pkg::*; #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qmn_in_if.sink    in_i,
  qmn_out_if.source out_o
);
  localparam int unsigned QW    = FRAC_BITS + 2;
  localparam int unsigned SqSt  = RootW / 2;
  localparam int unsigned Depth = 4 + SqSt + QW;
  localparam int unsigned NumW  = ScW + FRAC_BITS + 2;

  logic en;
  logic [Depth-1:0] vld_q;
  logic             out_vld_q;
  qout_t            out_q;

  assign en          = !out_vld_q || out_o.ready;
  assign in_i.ready  = en;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[Depth-2:0], in_i.valid};
      out_vld_q <= vld_q[Depth-1];
    end
  end

  // stage 1: sixteen products
  logic signed [31:0] pr_q [16];
  always_ff @(posedge clk_i) begin
    if (en) begin
      pr_q[0]  <= in_i.data.lw * in_i.data.rw;
      pr_q[1]  <= in_i.data.lx * in_i.data.rx;
      pr_q[2]  <= in_i.data.ly * in_i.data.ry;
      pr_q[3]  <= in_i.data.lz * in_i.data.rz;
      pr_q[4]  <= in_i.data.lw * in_i.data.rx;
      pr_q[5]  <= in_i.data.lx * in_i.data.rw;
      pr_q[6]  <= in_i.data.ly * in_i.data.rz;
      pr_q[7]  <= in_i.data.lz * in_i.data.ry;
      pr_q[8]  <= in_i.data.lw * in_i.data.ry;
      pr_q[9]  <= in_i.data.ly * in_i.data.rw;
      pr_q[10] <= in_i.data.lz * in_i.data.rx;
      pr_q[11] <= in_i.data.lx * in_i.data.rz;
      pr_q[12] <= in_i.data.lw * in_i.data.rz;
      pr_q[13] <= in_i.data.lz * in_i.data.rw;
      pr_q[14] <= in_i.data.lx * in_i.data.ry;
      pr_q[15] <= in_i.data.ly * in_i.data.rx;
    end
  end

  function automatic logic signed [ProdW-1:0] sx(input logic signed [31:0] v);
    sx = ProdW'(v);
  endfunction

  // stage 2: sums, magnitudes, signs
  logic [3:0][MagW-1:0] mag_q;
  logic [3:0]           neg_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        logic signed [ProdW-1:0] p;
        case (k)
          0: p = sx(pr_q[0]) - sx(pr_q[1]) - sx(pr_q[2]) - sx(pr_q[3]);
          1: p = sx(pr_q[4]) + sx(pr_q[5]) + sx(pr_q[6]) - sx(pr_q[7]);
          2: p = sx(pr_q[8]) + sx(pr_q[9]) + sx(pr_q[10]) - sx(pr_q[11]);
          default: p = sx(pr_q[12]) + sx(pr_q[13]) + sx(pr_q[14]) - sx(pr_q[15]);
        endcase
        neg_q[k] <= p[ProdW-1];
        mag_q[k] <= p[ProdW-1] ? MagW'(-p) : MagW'(p);
      end
    end
  end

  // stage 3: common shift into [2^30, 2^31)
  logic [3:0][ScW-1:0] a_q;
  logic [3:0]          neg3_q;
  logic                zero3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      logic [MagW-1:0] orv;
      logic [5:0]      sh;
      orv = mag_q[0] | mag_q[1] | mag_q[2] | mag_q[3];
      sh  = '0;
      for (int b = 0; b < ScW; b++) begin
        if (orv[b]) sh = 6'(ScW - 1 - b);
      end
      zero3_q <= (orv == '0);
      neg3_q  <= neg_q;
      for (int k = 0; k < 4; k++) begin
        if (orv[MagW-1:ScW] != '0) a_q[k] <= ScW'(mag_q[k] >> 1);
        else                       a_q[k] <= ScW'(mag_q[k] << sh);
      end
    end
  end

  // stage 4: squares, then sum
  logic [3:0][61:0] sq_q;
  logic [3:0][ScW-1:0] a4_q;
  logic [3:0]          neg4_q;
  logic                zero4_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) sq_q[k] <= 62'(a_q[k]) * 62'(a_q[k]);
      a4_q    <= a_q;
      neg4_q  <= neg3_q;
      zero4_q <= zero3_q;
    end
  end

  logic [SqW-1:0]        s_sum;
  logic [4:0][ScW:0]     side_in, side_out;
  logic [RootW-1:0]      root;
  assign s_sum = SqW'(sq_q[0]) + SqW'(sq_q[1]) + SqW'(sq_q[2]) + SqW'(sq_q[3]);
  always_comb begin
    for (int k = 0; k < 4; k++) side_in[k] = {neg4_q[k], a4_q[k]};
    side_in[4] = (ScW+1)'(zero4_q);
  end

  qmn_isqrt #(.Extra(5)) u_sqrt (
    .clk_i, .en_i(en), .s_i(s_sum), .side_i(side_in),
    .root_o(root), .side_o(side_out)
  );

  logic [3:0][QW-1:0] q;
  logic [RootW:0]     den;
  assign den = {root, 1'b0};
  for (genvar k = 0; k < 4; k++) begin : g_div
    logic [NumW+RootW-1:0] num;
    assign num = ((NumW+RootW)'(side_out[k][ScW-1:0]) << (FRAC_BITS + 1))
               + (NumW+RootW)'(root);
    qmn_div #(.QW(QW), .DW(RootW+1)) u_div (
      .clk_i, .en_i(en), .num_i((RootW+1+QW)'(num)), .den_i(den), .q_o(q[k])
    );
  end

  logic [QW-1:0][4:0] sd_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= {side_out[4][0], side_out[3][ScW], side_out[2][ScW],
                  side_out[1][ScW], side_out[0][ScW]};
      for (int i = 1; i < QW; i++) sd_q[i] <= sd_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      logic [QW-1:0] lim;
      logic [15:0]   m;
      lim = QW'(1) << FRAC_BITS;
      for (int k = 0; k < 4; k++) begin
        logic [QW-1:0] qq;
        qq = (q[k] > lim) ? lim : q[k];
        if (sd_q[QW-1][k]) m = (32'(qq) > 32'd32768) ? 16'h8000 : 16'(qq);
        else               m = (32'(qq) > 32'd32767) ? 16'h7fff : 16'(qq);
        if (sd_q[QW-1][4]) m = '0;
        else if (sd_q[QW-1][k]) m = 16'(-m);
        case (k)
          0: out_q.w <= m;
          1: out_q.x <= m;
          2: out_q.y <= m;
          default: out_q.z <= m;
        endcase
      end
      out_q.zero_length <= sd_q[QW-1][4];
    end
  end
endmodule

// ===== rtl/qmn_isqrt.sv =====
`timescale 1ns / 1ps
// Pipelined restoring square root, two result bits per stage.
module qmn_isqrt import qmn_pkg::*; #(
  parameter int unsigned Extra = 1
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [SqW-1:0]         s_i,
  input  logic [Extra-1:0][ScW:0] side_i,
  output logic [RootW-1:0]       root_o,
  output logic [Extra-1:0][ScW:0] side_o
);
  localparam int unsigned Stages = RootW / 2;
  logic [SqW-1:0]          rem_q  [Stages];
  logic [RootW-1:0]        root_q [Stages];
  logic [Extra-1:0][ScW:0] side_q [Stages];

  for (genvar g = 0; g < Stages; g++) begin : g_st
    logic [SqW-1:0]          rem_s, rem_d;
    logic [RootW-1:0]        root_s, root_d;
    logic [Extra-1:0][ScW:0] side_s;
    if (g == 0) begin : g_head
      assign rem_s  = s_i;
      assign root_s = '0;
      assign side_s = side_i;
    end else begin : g_body
      assign rem_s  = rem_q[g-1];
      assign root_s = root_q[g-1];
      assign side_s = side_q[g-1];
    end
    always_comb begin
      logic [RootW-1:0] r;
      logic [SqW-1:0]   rm;
      logic [RootW+1:0] t;
      r  = root_s;
      rm = rem_s;
      for (int b = 0; b < 2; b++) begin
        // trial: (4r+1) against the remainder bits brought down
        t = {r, 2'b01};
        if ((rm >> (SqW - 2 - 2 * (2 * g + b))) >= SqW'(t)) begin
          rm = rm - (SqW'(t) << (SqW - 2 - 2 * (2 * g + b)));
          r  = {r[RootW-2:0], 1'b1};
        end else begin
          r  = {r[RootW-2:0], 1'b0};
        end
      end
      rem_d  = rm;
      root_d = r;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_d;
        root_q[g] <= root_d;
        side_q[g] <= side_s;
      end
    end
  end

  assign root_o = root_q[Stages-1];
  assign side_o = side_q[Stages-1];
endmodule

// ===== rtl/qmn_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider: q = floor(num / den), one quotient bit per stage.
module qmn_div import qmn_pkg::*; #(
  parameter int unsigned QW = 16,
  parameter int unsigned DW = 33
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [DW+QW-1:0] num_i,
  input  logic [DW-1:0]   den_i,
  output logic [QW-1:0]   q_o
);
  logic [DW+QW-1:0] n_q [QW];
  logic [DW-1:0]    d_q [QW];
  logic [QW-1:0]    q_q [QW];
  for (genvar g = 0; g < QW; g++) begin : g_st
    localparam int unsigned Sh = QW - 1 - g;
    logic [DW+QW-1:0] n_s, n_d;
    logic [DW-1:0]    d_s;
    logic [QW-1:0]    q_s;
    logic             bit_d;
    if (g == 0) begin : g_head
      assign n_s = num_i;
      assign d_s = den_i;
      assign q_s = '0;
    end else begin : g_body
      assign n_s = n_q[g-1];
      assign d_s = d_q[g-1];
      assign q_s = q_q[g-1];
    end
    always_comb begin
      bit_d = (n_s >> Sh) >= (DW+QW)'(d_s);
      n_d   = bit_d ? n_s - ((DW+QW)'(d_s) << Sh) : n_s;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[g] <= n_d;
        d_q[g] <= d_s;
        q_q[g] <= {q_s[QW-2:0], bit_d};
      end
    end
  end
  assign q_o = q_q[QW-1];
endmodule

// ===== rtl/qmn_checker.sv =====
`timescale 1ns / 1ps
`include "quaternion_multiply_normalize_unit_assert.svh"
module qmn_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i, out_valid_i, out_ready_i,
  input logic zero_len_i,
  input logic [15:0] w_i
);
  `QMN_ASSERT_NXT(a_hold, out_valid_i && !out_ready_i, out_valid_i)
  `QMN_ASSERT_IMP(a_rdy, !out_valid_i, in_ready_i)
  `QMN_ASSERT_IMP(a_zero, out_valid_i && zero_len_i, w_i == 16'h0)
endmodule

bind quaternion_multiply_normalize_unit qmn_checker u_chk (
  .clk_i, .rst_ni, .in_ready_i(in_i.ready),
  .out_valid_i(out_o.valid), .out_ready_i(out_o.ready),
  .zero_len_i(out_o.data.zero_length), .w_i(out_o.data.w)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import qmn_pkg::*;

  localparam int unsigned FracBits = 14;
  localparam int unsigned Latency = 4 + 16 + FracBits + 2 + 1;
  localparam int unsigned StallLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  qmn_in_if in_i ();
  qmn_out_if out_o ();

  quaternion_multiply_normalize_unit #(.FRAC_BITS(FracBits)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .out_o (out_o)
  );

  always #1 clk_i = ~clk_i;

  qin_t  pending_q[$];
  qout_t expected_q[$];
  int    errors = 0;
  bit    hold_off = 1'b0;

  function automatic logic [63:0] int_sqrt(logic [63:0] s);
    logic [63:0] rem, root, b;
    rem = s;
    root = '0;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic qout_t normalised_product(qin_t a);
    longint p[4];
    logic [63:0] mag[4];
    logic [63:0] m, s, n, num, q;
    qout_t r;
    m = 0;
    s = 0;
    p[0] = longint'(a.lw) * a.rw - longint'(a.lx) * a.rx - longint'(a.ly) * a.ry
           - longint'(a.lz) * a.rz;
    p[1] = longint'(a.lw) * a.rx + longint'(a.lx) * a.rw + longint'(a.ly) * a.rz
           - longint'(a.lz) * a.ry;
    p[2] = longint'(a.lw) * a.ry + longint'(a.ly) * a.rw + longint'(a.lz) * a.rx
           - longint'(a.lx) * a.rz;
    p[3] = longint'(a.lw) * a.rz + longint'(a.lz) * a.rw + longint'(a.lx) * a.ry
           - longint'(a.ly) * a.rx;
    for (int k = 0; k < 4; k++) begin
      mag[k] = p[k] < 0 ? 64'(-p[k]) : 64'(p[k]);
      if (mag[k] > m) m = mag[k];
    end
    r = '0;
    if (m == 0) begin
      r.zero_length = 1'b1;
      return r;
    end
    if (m >= (64'd1 << 31)) begin
      for (int k = 0; k < 4; k++) mag[k] = mag[k] >> 1;
    end else begin
      while (m < (64'd1 << 30)) begin
        m = m << 1;
        for (int k = 0; k < 4; k++) mag[k] = mag[k] << 1;
      end
    end
    for (int k = 0; k < 4; k++) s = s + mag[k] * mag[k];
    n = int_sqrt(s);
    for (int k = 0; k < 4; k++) begin
      num = ((mag[k] << FracBits) << 1) + n;
      q = num / (n << 1);
      if (q > (64'd1 << FracBits)) q = 64'd1 << FracBits;
      if (p[k] < 0) begin
        if (q > 32768) q = 32768;
        q = -q;
      end else if (q > 32767) begin
        q = 32767;
      end
      case (k)
        0: r.w = q[15:0];
        1: r.x = q[15:0];
        2: r.y = q[15:0];
        default: r.z = q[15:0];
      endcase
    end
    return r;
  endfunction

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return comp_t'(int'($urandom_range(0, 7)) - 3);
      4: return 16'sh4000;
      default: return comp_t'($urandom);
    endcase
  endfunction

  function automatic qin_t make_item(comp_t a, comp_t b, comp_t c, comp_t d,
                                     comp_t e, comp_t f, comp_t g, comp_t h);
    qin_t t;
    t.lw = a; t.lx = b; t.ly = c; t.lz = d;
    t.rw = e; t.rx = f; t.ry = g; t.rz = h;
    return t;
  endfunction

  // sender: bursts with gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_i.valid <= 1'b0;
      in_i.data <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        expected_q.push_back(normalised_product(in_i.data));
        void'(pending_q.pop_front());
      end
      if (in_i.valid && !in_i.ready) begin
        // hold current item
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_i.valid <= 1'b0;
      end else if (!hold_off && pending_q.size() > 0) begin
        in_i.valid <= 1'b1;
        in_i.data <= pending_q[0];
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_i.valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern
  logic [7:0] stall_lfsr;
  int phase_cnt;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_o.ready <= 1'b0;
      stall_lfsr <= 8'h5a;
      phase_cnt <= 0;
    end else begin
      stall_lfsr <= {stall_lfsr[6:0],
                     stall_lfsr[7] ^ stall_lfsr[5] ^ stall_lfsr[4] ^ stall_lfsr[3]};
      phase_cnt <= (phase_cnt + 1) % 400;
      out_o.ready <= (phase_cnt < 100) ? 1'b1 : (stall_lfsr[1:0] != 2'b00);
    end
  end

  // monitor
  qout_t want;
  always @(posedge clk_i) begin
    if (rst_ni && out_o.valid && out_o.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_o.data);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_o.data.w !== want.w)
          $display("%0t: w expected %0d actual %0d", $time, want.w, out_o.data.w);
        if (out_o.data.x !== want.x)
          $display("%0t: x expected %0d actual %0d", $time, want.x, out_o.data.x);
        if (out_o.data.y !== want.y)
          $display("%0t: y expected %0d actual %0d", $time, want.y, out_o.data.y);
        if (out_o.data.z !== want.z)
          $display("%0t: z expected %0d actual %0d", $time, want.z, out_o.data.z);
        if (out_o.data.zero_length !== want.zero_length)
          $display("%0t: zero_length expected %0b actual %0b", $time,
                   want.zero_length, out_o.data.zero_length);
        if (out_o.data !== want) errors++;
      end
    end
  end

  // watchdog
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_i.valid && in_i.ready) || (out_o.valid && out_o.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    comp_t mx, mn, zr, p1, m1;
    mx = 16'sh7fff;
    mn = 16'sh8000;
    zr = 16'sh0000;
    p1 = 16'sh0001;
    m1 = 16'shffff;
    pending_q.push_back(make_item(zr, zr, zr, zr, zr, zr, zr, zr));
    pending_q.push_back(make_item(mx, mx, mx, mx, mx, mx, mx, mx));
    pending_q.push_back(make_item(mn, mn, mn, mn, mn, mn, mn, mn));
    pending_q.push_back(make_item(mx, zr, zr, zr, mn, zr, zr, zr));
    pending_q.push_back(make_item(16'sh4000, zr, zr, zr, 16'sh4000, zr, zr, zr));
    pending_q.push_back(make_item(zr, 16'sh4000, zr, zr, zr, 16'sh4000, zr, zr));
    pending_q.push_back(make_item(zr, zr, 16'sh4000, zr, zr, zr, zr, 16'sh4000));
    pending_q.push_back(make_item(p1, zr, zr, zr, p1, zr, zr, zr));
    pending_q.push_back(make_item(p1, p1, p1, p1, m1, p1, p1, p1));
    pending_q.push_back(make_item(mn, mx, mn, mx, mx, mn, mx, mn));
    pending_q.push_back(make_item(zr, zr, zr, zr, mx, mn, 16'sd5, -16'sd7));
    pending_q.push_back(make_item(16'sh5555, -16'sh2aab, 16'sd3, zr, mx, zr, zr, p1));
    pending_q.push_back(make_item(m1, m1, m1, m1, m1, m1, m1, m1));
    pending_q.push_back(make_item(16'sh2d41, zr, 16'sh2d41, zr, 16'sh2d41, 16'sh2d41,
                                  zr, zr));
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0);
    @(posedge clk_i);
    hold_off = 1'b1;
    wait (expected_q.size() == 0);
    hold_off = 1'b0;
    for (int i = 0; i < 600; i++) begin
      pending_q.push_back(make_item(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                                    rand_comp(), rand_comp(), rand_comp(), rand_comp()));
    end
    wait (pending_q.size() == 0);
    wait (expected_q.size() == 0);
    repeat (Latency * 4) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== quaternion_multiply_normalize_unit.f =====
+incdir+rtl
rtl/qmn_pkg.sv
rtl/qmn_if.sv
rtl/qmn_isqrt.sv
rtl/qmn_div.sv
rtl/quaternion_multiply_normalize_unit.sv
rtl/qmn_checker.sv
tb/testbench.sv
